// ----- rtl/core/shortest_remaining_time_scheduler_defines.svh -----
// assertion macros used by the scheduler engine rtl
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define SRTS_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRTS_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/srt_pkg.sv -----
// shared types and constants of the shortest remaining time scheduler
`default_nettype none

package srt_pkg;

    localparam int SLOTS          = 64;
    localparam int SLOT_BITS      = $clog2(SLOTS);
    localparam int TIME_BITS      = 24;
    localparam int ARR_BITS       = 16;
    localparam int REM_BITS       = 16;
    localparam int PCOUNT_BITS    = 7;
    localparam int CNT_BITS       = 7;
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 104;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } srt_state_t;

    typedef struct packed {
        logic [ARR_BITS-1:0]  arrival;
        logic [REM_BITS-1:0]  remaining;
        logic [TIME_BITS-1:0] waiting;
    } srt_entry_t;

    typedef struct packed {
        logic                   start;
        logic                   load;
        logic [SLOT_BITS-1:0]   slot;
        logic [ARR_BITS-1:0]    arrival;
        logic [REM_BITS-1:0]    burst;
        logic [PCOUNT_BITS-1:0] n;
        logic [TIME_BITS-1:0]   t;
    } srt_cmd_t;

    typedef struct packed {
        logic                 idle;
        logic                 done;
        logic                 load;
        logic                 found;
        logic [SLOT_BITS-1:0] best;
        logic                 finished;
        logic [ARR_BITS-1:0]  arrival;
        logic [TIME_BITS-1:0] waiting;
    } srt_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/srt_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/srt_engine.sv -----
// slot table with the minimum search pass and the update pass
`default_nettype none
`include "shortest_remaining_time_scheduler_defines.svh"

module srt_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire srt_pkg::srt_cmd_t cmd,
    input  wire logic              ack,
    output srt_pkg::srt_stat_t     stat
);

    srt_pkg::srt_state_t state_reg, state_next;

    logic [srt_pkg::PCOUNT_BITS-1:0] idx_reg, idx_next;
    logic                            rd_vld_reg;
    logic [srt_pkg::SLOT_BITS-1:0]   rd_idx_reg;
    logic                            found_reg;
    logic [srt_pkg::SLOT_BITS-1:0]   best_reg;
    logic [srt_pkg::REM_BITS-1:0]    best_rem_reg;
    logic                            fin_reg;
    logic [srt_pkg::ARR_BITS-1:0]    fin_arr_reg;
    logic [srt_pkg::TIME_BITS-1:0]   fin_wait_reg;
    logic                            load_reg;

    logic                          rd_en;
    logic [srt_pkg::SLOT_BITS-1:0] rd_addr;
    logic                          wr_en;
    logic [srt_pkg::SLOT_BITS-1:0] wr_addr;
    srt_pkg::srt_entry_t           wr_data;
    srt_pkg::srt_entry_t           rd_entry;
    srt_pkg::srt_entry_t           upd_entry;
    srt_pkg::srt_entry_t           load_entry;
    logic                          elig;
    logic                          is_best;
    logic [srt_pkg::REM_BITS-1:0]  rem_dec;
    logic                          pass_end;

    srt_ram #(
        .WIDTH ($bits(srt_pkg::srt_entry_t)),
        .DEPTH (srt_pkg::SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // per-entry datapath
    always_comb begin
        elig    = (srt_pkg::TIME_BITS'(rd_entry.arrival) < cmd.t) &&
                  (rd_entry.remaining != '0);
        is_best = found_reg && (rd_idx_reg == best_reg);
        rem_dec = rd_entry.remaining - srt_pkg::REM_BITS'(1);
        upd_entry = rd_entry;
        if (is_best) begin
            upd_entry.remaining = rem_dec;
        end else if (elig && (rd_entry.waiting != '1)) begin
            upd_entry.waiting = rd_entry.waiting + srt_pkg::TIME_BITS'(1);
        end
        load_entry.arrival   = cmd.arrival;
        load_entry.remaining = cmd.burst;
        load_entry.waiting   = '0;
        pass_end = (idx_reg >= cmd.n) && !rd_vld_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srt_pkg::ST_IDLE: begin
                if (cmd.start) begin
                    state_next = cmd.load ? srt_pkg::ST_DONE : srt_pkg::ST_SCAN;
                end
            end
            srt_pkg::ST_SCAN: begin
                if (pass_end) begin
                    state_next = srt_pkg::ST_UPDATE;
                end
            end
            srt_pkg::ST_UPDATE: begin
                if (pass_end) begin
                    state_next = srt_pkg::ST_DONE;
                end
            end
            srt_pkg::ST_DONE: begin
                if (ack) begin
                    state_next = srt_pkg::ST_IDLE;
                end
            end
            default: state_next = srt_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[srt_pkg::SLOT_BITS-1:0];
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = upd_entry;
        idx_next = idx_reg;
        case (state_reg)
            srt_pkg::ST_IDLE: begin
                idx_next = '0;
                wr_addr  = cmd.slot;
                wr_data  = load_entry;
                wr_en    = cmd.start && cmd.load;
            end
            srt_pkg::ST_SCAN: begin
                rd_en = idx_reg < cmd.n;
                if (rd_en) begin
                    idx_next = idx_reg + srt_pkg::PCOUNT_BITS'(1);
                end else if (pass_end) begin
                    idx_next = '0;
                end
            end
            srt_pkg::ST_UPDATE: begin
                rd_en = idx_reg < cmd.n;
                wr_en = rd_vld_reg;
                if (rd_en) begin
                    idx_next = idx_reg + srt_pkg::PCOUNT_BITS'(1);
                end
            end
            srt_pkg::ST_DONE: begin
                idx_next = '0;
            end
            default: idx_next = '0;
        endcase
        stat.idle     = state_reg == srt_pkg::ST_IDLE;
        stat.done     = state_reg == srt_pkg::ST_DONE;
        stat.load     = load_reg;
        stat.found    = found_reg;
        stat.best     = best_reg;
        stat.finished = fin_reg;
        stat.arrival  = fin_arr_reg;
        stat.waiting  = fin_wait_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= srt_pkg::ST_IDLE;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            load_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_en;
            if (state_reg == srt_pkg::ST_IDLE && cmd.start) begin
                found_reg <= 1'b0;
                fin_reg   <= 1'b0;
                load_reg  <= cmd.load;
            end
            if (state_reg == srt_pkg::ST_SCAN && rd_vld_reg && elig &&
                (!found_reg || rd_entry.remaining < best_rem_reg)) begin
                found_reg <= 1'b1;
            end
            if (state_reg == srt_pkg::ST_UPDATE && rd_vld_reg && is_best &&
                rem_dec == '0) begin
                fin_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= idx_reg[srt_pkg::SLOT_BITS-1:0];
        if (state_reg == srt_pkg::ST_SCAN && rd_vld_reg && elig &&
            (!found_reg || rd_entry.remaining < best_rem_reg)) begin
            best_reg     <= rd_idx_reg;
            best_rem_reg <= rd_entry.remaining;
        end
        if (state_reg == srt_pkg::ST_UPDATE && rd_vld_reg && is_best) begin
            fin_arr_reg  <= rd_entry.arrival;
            fin_wait_reg <= rd_entry.waiting;
        end
    end

    `SRTS_ASSERT_IMP(a_rd_vld_busy, aclk, aresetn, rd_vld_reg,
        state_reg == srt_pkg::ST_SCAN || state_reg == srt_pkg::ST_UPDATE,
        "read data returned outside a pass")
    `SRTS_ASSERT_IMP(a_no_rw_clash, aclk, aresetn, wr_en && rd_en,
        wr_addr != rd_addr, "write back collides with the next read")
    `SRTS_ASSERT_IMP(a_fin_needs_win, aclk, aresetn, fin_reg, found_reg,
        "completion flagged without a chosen slot")
    `SRTS_ASSERT_NXT(a_ack_to_idle, aclk, aresetn,
        state_reg == srt_pkg::ST_DONE && ack, state_reg == srt_pkg::ST_IDLE,
        "engine did not release after result taken")

endmodule

`default_nettype wire

// ----- rtl/core/shortest_remaining_time_scheduler.sv -----
// Preemptive shortest-remaining-time-first scheduler over 64 process slots.
// The slot table (arrival, remaining and waiting ticks) lives in one
// single-read, single-write memory with a registered read. A load item writes
// its slot and restarts the run (the tick and completion counters
// go to zero). A tick item reads the slots in use twice: a first pass finds
// the eligible slot with the least remaining time, a second pass rewrites
// every slot in use, decrementing the chosen slot's remaining time and
// incrementing the waiting count of each other eligible slot. With n slots
// in use (process_count, capped at 64) each pass reads the n slots and then
// drains the read pipeline; the result then goes to the output register and
// the engine returns to idle, and only then is a new item accepted. A full
// output register stalls the engine only when the next result is ready.
// The next item is accepted while the previous result waits in the output
// register. process_count is to be written only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module shortest_remaining_time_scheduler (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // slot, arrival, burst
    input  wire logic [srt_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    // func
    input  wire logic [0:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // chosen_slot, completion_time, turnaround, waiting_time, tick_time, all_done
    output logic      [srt_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    // ran, finished
    output logic      [1:0]                          m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [srt_pkg::PCOUNT_BITS-1:0]     cfg_data
);

    logic [srt_pkg::PCOUNT_BITS-1:0] pcount_reg;
    logic [srt_pkg::TIME_BITS-1:0]   tick_reg, tick_next;
    logic [srt_pkg::CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                            m_tvalid_reg;
    logic [srt_pkg::OUT_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                      m_tuser_reg, m_tuser_next;

    logic [srt_pkg::PCOUNT_BITS-1:0] n_use;
    srt_pkg::srt_cmd_t               cmd;
    srt_pkg::srt_stat_t              stat;
    logic                            ack;
    logic                            ran;
    logic [srt_pkg::TIME_BITS-1:0]   ct;
    logic [srt_pkg::TIME_BITS-1:0]   tat;
    logic [srt_pkg::TIME_BITS-1:0]   wt;
    logic [srt_pkg::TIME_BITS-1:0]   tt;
    logic [srt_pkg::SLOT_BITS-1:0]   chosen;
    logic                            all_done;

    assign cfg_ready = 1'b1;
    assign n_use = (pcount_reg > srt_pkg::PCOUNT_BITS'(srt_pkg::SLOTS)) ?
                   srt_pkg::PCOUNT_BITS'(srt_pkg::SLOTS) : pcount_reg;

    assign s_tready = stat.idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        cmd.start   = s_tvalid && s_tready;
        cmd.load    = s_tuser[0] == srt_pkg::FUNC_LOAD;
        cmd.slot    = s_tdata[5:0];
        cmd.arrival = s_tdata[21:6];
        cmd.burst   = s_tdata[37:22];
        cmd.n       = n_use;
        cmd.t       = tick_reg;
    end

    srt_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .ack     (ack),
        .stat    (stat)
    );

    assign ack = stat.done && (!m_tvalid_reg || m_tready);

    // result and counter update
    always_comb begin
        ran      = !stat.load && stat.found;
        chosen   = ran ? stat.best : '0;
        ct       = '0;
        tat      = '0;
        wt       = '0;
        tt       = stat.load ? '0 : tick_reg;
        tick_next = tick_reg;
        cnt_next  = cnt_reg;
        if (stat.load) begin
            tick_next = '0;
            cnt_next  = '0;
        end else begin
            if (tick_reg != '1) begin
                tick_next = tick_reg + srt_pkg::TIME_BITS'(1);
            end
            if (stat.finished) begin
                ct  = tick_reg;
                tat = tick_reg - srt_pkg::TIME_BITS'(stat.arrival);
                wt  = stat.waiting;
                if (cnt_reg != '1) begin
                    cnt_next = cnt_reg + srt_pkg::CNT_BITS'(1);
                end
            end
        end
        all_done     = cnt_next >= n_use;
        m_tdata_next = {1'b0, all_done, tt, wt, tat, ct, chosen};
        m_tuser_next = {ran && stat.finished, ran};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg   <= srt_pkg::PCOUNT_BITS'(1);
            tick_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pcount_reg <= cfg_data;
            end
            if (ack) begin
                tick_reg     <= tick_next;
                cnt_reg      <= cnt_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ack) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

endmodule

`default_nettype wire
